// ===== design/pbfl_pkg.sv =====
// shared types, constants and codes for the page block free list allocator
package pbfl_pkg;

   localparam int DEPTH_DEF       = 1024;
   localparam int COUNT_BITS_DEF  = 32;
   localparam int BLOCK_BYTES     = 4096;
   localparam int BLOCK_SHIFT     = 12;
   localparam int ADDR_W          = 48;
   localparam int BLKNUM_W        = ADDR_W - BLOCK_SHIFT;
   localparam int SIZE_W          = 16;
   localparam int FUNC_W          = 2;
   localparam int STATUS_W        = 2;
   localparam int CNT_OUT_W       = 32;
   localparam int CSR_IDX_W       = 2;
   localparam int NUM_COUNTERS    = 4;

   localparam logic [FUNC_W-1:0] FUNC_INIT  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGION_SIZE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE  = 2'd2;

   localparam int CNT_ALLOC_OK   = 0;
   localparam int CNT_ALLOC_FAIL = 1;
   localparam int CNT_FREE_OK    = 2;
   localparam int CNT_FREE_FAIL  = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FILL,
      ST_POST
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec_op;
      logic fill_step;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_fill;
      logic fill_last;
      logic rsp_free;
   } stat_type;

endpackage

// ===== design/pbfl_ctrl.sv =====
// sequencing state machine for the page block free list allocator
module pbfl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pbfl_pkg::stat_type stat,
   output pbfl_pkg::cmd_type  cmd
);
   import pbfl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = stat.init_fill ? ST_FILL : ST_POST;
         end
         ST_FILL: begin
            if (stat.fill_last) state_in = ST_POST;
         end
         ST_POST: begin
            if (stat.rsp_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall     = 1'b1;
      cmd.load_req  = 1'b0;
      cmd.exec_op   = 1'b0;
      cmd.fill_step = 1'b0;
      cmd.load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall    = 1'b0;
            cmd.load_req = req_valid;
         end
         ST_EXEC: begin
            cmd.exec_op = 1'b1;
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
         end
         ST_POST: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== design/pbfl_datapath.sv =====
// free list memory, pointers, operation counters and result register
module pbfl_datapath #(
   parameter int DEPTH      = pbfl_pkg::DEPTH_DEF,
   parameter int COUNT_BITS = pbfl_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  pbfl_pkg::cmd_type               cmd,
   output pbfl_pkg::stat_type              stat,
   input  logic [pbfl_pkg::FUNC_W-1:0]     req_func,
   input  logic [pbfl_pkg::ADDR_W-1:0]     req_block_addr,
   input  logic [pbfl_pkg::SIZE_W-1:0]     req_req_size,
   input  logic [pbfl_pkg::ADDR_W-1:0]     region_base,
   input  logic [pbfl_pkg::ADDR_W-1:0]     region_size,
   input  logic [pbfl_pkg::SIZE_W-1:0]     pool_block_size,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [pbfl_pkg::STATUS_W-1:0]   rsp_status,
   output logic [pbfl_pkg::ADDR_W-1:0]     rsp_out_addr,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]  rsp_alloc_ok_count,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]  rsp_alloc_fail_count,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]  rsp_free_ok_count,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]  rsp_free_fail_count
);
   import pbfl_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   logic [BLKNUM_W-1:0] free_blocks_mem [DEPTH];
   logic [BLKNUM_W-1:0] rd_data_ff;

   // latched request
   logic [FUNC_W-1:0]   func_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [SIZE_W-1:0]   size_ff;

   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rem_ff, rem_in;
   logic [BLKNUM_W-1:0] fill_blk_ff, fill_blk_in;
   logic [COUNT_BITS-1:0] op_cnt_ff [NUM_COUNTERS];
   logic [COUNT_BITS-1:0] op_cnt_in [NUM_COUNTERS];

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic                res_hit_ff, res_hit_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [CNT_OUT_W-1:0] rsp_cnt_ff [NUM_COUNTERS];

   logic                wr_en;
   logic [BLKNUM_W-1:0] wr_data;
   logic                rd_en;

   logic [BLKNUM_W-1:0] nblk;
   logic                init_ok;
   logic                size_ok;

   assign nblk    = region_size[ADDR_W-1:BLOCK_SHIFT];
   assign init_ok = (region_base != '0)
                 && (region_base[BLOCK_SHIFT-1:0] == '0)
                 && (region_size != '0)
                 && (region_size[BLOCK_SHIFT-1:0] == '0)
                 && (nblk <= BLKNUM_W'(DEPTH))
                 && (pool_block_size == SIZE_W'(BLOCK_BYTES));
   assign size_ok = (size_ff == SIZE_W'(BLOCK_BYTES));

   assign stat.init_fill = (func_ff == FUNC_INIT) && init_ok;
   assign stat.fill_last = (rem_ff == CNT_W'(1));
   assign stat.rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      rem_in        = rem_ff;
      fill_blk_in   = fill_blk_ff;
      op_cnt_in     = op_cnt_ff;
      res_status_in = res_status_ff;
      res_hit_in    = res_hit_ff;
      wr_en         = 1'b0;
      wr_data       = addr_ff[ADDR_W-1:BLOCK_SHIFT];
      rd_en         = 1'b0;

      if (cmd.exec_op) begin
         res_status_in = STATUS_INVALID;
         res_hit_in    = 1'b0;
         case (func_ff)
            FUNC_INIT: begin
               head_in  = '0;
               tail_in  = '0;
               count_in = '0;
               if (init_ok) begin
                  for (int i = 0; i < NUM_COUNTERS; i++) op_cnt_in[i] = '0;
                  fill_blk_in   = region_base[ADDR_W-1:BLOCK_SHIFT];
                  rem_in        = CNT_W'(nblk);
                  res_status_in = STATUS_OK;
               end
            end
            FUNC_ALLOC: begin
               if (!size_ok) begin
                  op_cnt_in[CNT_ALLOC_FAIL] = op_cnt_ff[CNT_ALLOC_FAIL] + 1'b1;
               end else if (count_ff == '0) begin
                  res_status_in = STATUS_EMPTY;
                  op_cnt_in[CNT_ALLOC_FAIL] = op_cnt_ff[CNT_ALLOC_FAIL] + 1'b1;
               end else begin
                  rd_en         = 1'b1;
                  head_in       = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
                  count_in      = count_ff - 1'b1;
                  res_status_in = STATUS_OK;
                  res_hit_in    = 1'b1;
                  op_cnt_in[CNT_ALLOC_OK] = op_cnt_ff[CNT_ALLOC_OK] + 1'b1;
               end
            end
            FUNC_FREE: begin
               if (addr_ff == '0 || !size_ok) begin
                  op_cnt_in[CNT_FREE_FAIL] = op_cnt_ff[CNT_FREE_FAIL] + 1'b1;
               end else if (count_ff == CNT_FULL) begin
                  res_status_in = STATUS_FULL;
                  op_cnt_in[CNT_FREE_FAIL] = op_cnt_ff[CNT_FREE_FAIL] + 1'b1;
               end else begin
                  wr_en         = 1'b1;
                  tail_in       = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;
                  count_in      = count_ff + 1'b1;
                  res_status_in = STATUS_OK;
                  op_cnt_in[CNT_FREE_OK] = op_cnt_ff[CNT_FREE_OK] + 1'b1;
               end
            end
            default: begin
               res_status_in = STATUS_INVALID;
            end
         endcase
      end

      if (cmd.fill_step) begin
         wr_en       = 1'b1;
         wr_data     = fill_blk_ff;
         tail_in     = (tail_ff == IDX_LAST) ? '0 : tail_ff + 1'b1;
         count_in    = count_ff + 1'b1;
         fill_blk_in = fill_blk_ff + 1'b1;
         rem_in      = rem_ff - 1'b1;
      end
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_COUNTERS; i++) op_cnt_ff[i] <= '0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
         op_cnt_ff    <= op_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_blk_ff   <= fill_blk_in;
      res_status_ff <= res_status_in;
      res_hit_ff    <= res_hit_in;
      if (cmd.load_req) begin
         func_ff <= req_func;
         addr_ff <= req_block_addr;
         size_ff <= req_req_size;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_hit_ff ? {rd_data_ff, BLOCK_SHIFT'(0)} : '0;
         for (int i = 0; i < NUM_COUNTERS; i++) rsp_cnt_ff[i] <= CNT_OUT_W'(op_cnt_ff[i]);
      end
   end

   // free list storage, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) free_blocks_mem[tail_ff] <= wr_data;
      if (rd_en) rd_data_ff <= free_blocks_mem[head_ff];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_out_addr         = rsp_addr_ff;
   assign rsp_alloc_ok_count   = rsp_cnt_ff[CNT_ALLOC_OK];
   assign rsp_alloc_fail_count = rsp_cnt_ff[CNT_ALLOC_FAIL];
   assign rsp_free_ok_count    = rsp_cnt_ff[CNT_FREE_OK];
   assign rsp_free_fail_count  = rsp_cnt_ff[CNT_FREE_FAIL];

endmodule

// ===== design/page_block_free_list_allocator.sv =====
// top level of the page block free list allocator: csr registers, controller and datapath
// alloc and free pass through the execute and post states before their result is registered
// a valid init walks the region one block per cycle in the fill state; an invalid init skips the fill
// requests are not overlapped: a new one is taken only in idle, after the previous one has
// passed execute and post (post waits while a result is held); a valid init also passes fill
// reset: synchronous active high; list empty, counters zero, csr registers to their defaults
module page_block_free_list_allocator #(
   parameter int DEPTH      = pbfl_pkg::DEPTH_DEF,
   parameter int COUNT_BITS = pbfl_pkg::COUNT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [pbfl_pkg::FUNC_W-1:0]       req_func,
   input  logic [pbfl_pkg::ADDR_W-1:0]       req_block_addr,
   input  logic [pbfl_pkg::SIZE_W-1:0]       req_req_size,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [pbfl_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pbfl_pkg::ADDR_W-1:0]       rsp_out_addr,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]    rsp_alloc_ok_count,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]    rsp_alloc_fail_count,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]    rsp_free_ok_count,
   output logic [pbfl_pkg::CNT_OUT_W-1:0]    rsp_free_fail_count,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbfl_pkg::ADDR_W-1:0]       csr_data
);
   import pbfl_pkg::*;

   // the free list memory is not cleared: entries are only read after they were written

   // configuration registers
   logic [ADDR_W-1:0] region_base_ff;
   logic [ADDR_W-1:0] region_size_ff;
   logic [SIZE_W-1:0] block_size_ff;
   logic              csr_wr;

   cmd_type  cmd;
   stat_type stat;

   // writes are always taken; index three is ignored
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         region_base_ff <= '0;
         region_size_ff <= '0;
         block_size_ff  <= SIZE_W'(BLOCK_BYTES);
      end else if (csr_wr) begin
         case (csr_index)
            CSR_REGION_BASE: region_base_ff <= csr_data;
            CSR_REGION_SIZE: region_size_ff <= csr_data;
            CSR_BLOCK_SIZE:  block_size_ff  <= csr_data[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer: idle, execute, region fill, post result
   pbfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // free list memory, pointers, counters and output register
   pbfl_datapath #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_func             (req_func),
      .req_block_addr       (req_block_addr),
      .req_req_size         (req_req_size),
      .region_base          (region_base_ff),
      .region_size          (region_size_ff),
      .pool_block_size      (block_size_ff),
      .rsp_stall            (rsp_stall),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_out_addr         (rsp_out_addr),
      .rsp_alloc_ok_count   (rsp_alloc_ok_count),
      .rsp_alloc_fail_count (rsp_alloc_fail_count),
      .rsp_free_ok_count    (rsp_free_ok_count),
      .rsp_free_fail_count  (rsp_free_fail_count)
   );

   // an accepted request is executed in the very next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> cmd.exec_op)
      else $error("accepted request not executed");

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid || !rsp_stall))
      else $error("pending result overwritten");

   // no request is taken while the region is being filled
   a_fill_stalls: assert property (@(posedge clock) disable iff (reset)
      cmd.fill_step |-> req_stall)
      else $error("request taken during region fill");

endmodule
